>>> rtl/core/segint_pkg.sv
// ============================================================================
// segint_pkg
// Shared types and codes for the segment intersection test pipeline.
// ============================================================================
package segint_pkg;

    // Which rule decided the result
    typedef enum logic [1:0] {
        CASE_VERTICAL = 2'd0,
        CASE_PARALLEL = 2'd1,
        CASE_GENERAL  = 2'd2
    } case_t;

    // Early flags worked out from the raw coordinates in the first stage
    typedef struct packed {
        logic both_vert;  // both segments have zero x extent
        logic nonvert;    // neither segment has zero x extent
        logic vert_hit;   // verdict of the both-vertical rule
        logic box_hit;    // some endpoint lies in the other's bounding box
    } seg_flags_t;

endpackage

>>> rtl/core/segint_classify.sv
// ============================================================================
// segint_classify
// First-stage logic: edge and offset vectors, vertical checks, the strict
// y-span rule for two vertical segments and the inclusive box tests.
// ============================================================================
module segint_classify
    import segint_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic signed [COORD_WIDTH-1:0] a1x,
    input  logic signed [COORD_WIDTH-1:0] a1y,
    input  logic signed [COORD_WIDTH-1:0] a2x,
    input  logic signed [COORD_WIDTH-1:0] a2y,
    input  logic signed [COORD_WIDTH-1:0] b1x,
    input  logic signed [COORD_WIDTH-1:0] b1y,
    input  logic signed [COORD_WIDTH-1:0] b2x,
    input  logic signed [COORD_WIDTH-1:0] b2y,
    output logic signed [COORD_WIDTH:0]   ax,
    output logic signed [COORD_WIDTH:0]   ay,
    output logic signed [COORD_WIDTH:0]   bx,
    output logic signed [COORD_WIDTH:0]   by,
    output logic signed [COORD_WIDTH:0]   dx,
    output logic signed [COORD_WIDTH:0]   dy,
    output seg_flags_t                    flags
);

    localparam int DW = COORD_WIDTH + 1;

    // Inclusive bounding-box test of point v against box p1..p2
    function automatic logic in_box(
        input logic signed [COORD_WIDTH-1:0] p1x,
        input logic signed [COORD_WIDTH-1:0] p1y,
        input logic signed [COORD_WIDTH-1:0] p2x,
        input logic signed [COORD_WIDTH-1:0] p2y,
        input logic signed [COORD_WIDTH-1:0] vx,
        input logic signed [COORD_WIDTH-1:0] vy
    );
        logic signed [COORD_WIDTH-1:0] lx;
        logic signed [COORD_WIDTH-1:0] hx;
        logic signed [COORD_WIDTH-1:0] ly;
        logic signed [COORD_WIDTH-1:0] hy;
        lx = (p1x < p2x) ? p1x : p2x;
        hx = (p1x < p2x) ? p2x : p1x;
        ly = (p1y < p2y) ? p1y : p2y;
        hy = (p1y < p2y) ? p2y : p1y;
        return (lx <= vx) && (hx >= vx) && (ly <= vy) && (hy >= vy);
    endfunction

    // Edge vectors and start-to-start offset, one bit wider than a coordinate
    assign ax = DW'(a2x) - DW'(a1x);
    assign ay = DW'(a2y) - DW'(a1y);
    assign bx = DW'(b2x) - DW'(b1x);
    assign by = DW'(b2y) - DW'(b1y);
    assign dx = DW'(b1x) - DW'(a1x);
    assign dy = DW'(b1y) - DW'(a1y);

    // Rule flags
    always_comb
    begin
        flags.both_vert = (a1x == a2x) && (b1x == b2x);
        flags.nonvert   = (a1x != a2x) && (b1x != b2x);
        // strict span tests, each in the start-to-end direction only
        flags.vert_hit  = (a1x == b1x) &&
                          (((a1y < b1y) && (b1y < a2y)) ||
                           ((a1y < b2y) && (b2y < a2y)) ||
                           ((b1y < a1y) && (a1y < b2y)) ||
                           ((b1y < a2y) && (a2y < b2y)));
        flags.box_hit   = in_box(a1x, a1y, a2x, a2y, b1x, b1y) ||
                          in_box(a1x, a1y, a2x, a2y, b2x, b2y) ||
                          in_box(b1x, b1y, b2x, b2y, a1x, a1y) ||
                          in_box(b1x, b1y, b2x, b2y, a2x, a2y);
    end

endmodule

>>> rtl/core/segment_intersection_test.sv
// ============================================================================
// segment_intersection_test
// Four-stage pipeline that decides whether two 2D segments cross.
// ============================================================================
// Usage:
//   Pair channel: pair_valid / pair_stall with the eight endpoint coordinates
//   (signed fixed point, COORD_WIDTH bits each). A transfer happens on a
//   rising edge with pair_valid high and pair_stall low.
//   Result channel: result_valid / result_stall with crosses and case_taken.
//   Stages: 1 vectors and compare flags, 2 six products, 3 cross products,
//   4 sign tests into the output register.
//   A pair passes through the stage 1, 2 and 3 registers into the output
//   register, where result_valid rises; throughput is one pair per cycle
//   while result_stall is low.
//   Each stage advances when it is empty or the stage after it moves, so
//   bubbles close up while the receiver stalls and pairs are still taken
//   until all four stages hold data; then pair_stall rises.
//   Reset empties the pipeline (all valid bits clear); the data registers
//   are not reset and there is no configuration.
// ============================================================================
module segment_intersection_test
    import segint_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pair_valid,
    output logic                          pair_stall,
    input  logic signed [COORD_WIDTH-1:0] first_start_x,
    input  logic signed [COORD_WIDTH-1:0] first_start_y,
    input  logic signed [COORD_WIDTH-1:0] first_end_x,
    input  logic signed [COORD_WIDTH-1:0] first_end_y,
    input  logic signed [COORD_WIDTH-1:0] second_start_x,
    input  logic signed [COORD_WIDTH-1:0] second_start_y,
    input  logic signed [COORD_WIDTH-1:0] second_end_x,
    input  logic signed [COORD_WIDTH-1:0] second_end_y,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          crosses,
    output logic [1:0]                    case_taken
);

    localparam int DW = COORD_WIDTH + 1;   // vector components
    localparam int PW = 2 * DW;            // products
    localparam int CW = PW + 1;            // cross products
    localparam int NSTAGE = 4;

    // Pipeline control
    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] adv;

    // Stage 1 results
    logic signed [DW-1:0] ax_next, ay_next, bx_next, by_next, dx_next, dy_next;
    seg_flags_t           flags_next;
    logic signed [DW-1:0] ax_reg, ay_reg, bx_reg, by_reg, dx_reg, dy_reg;
    seg_flags_t           flags1_reg;

    // Stage 2 products
    logic signed [PW-1:0] axby_reg, aybx_reg, axdy_reg, aydx_reg, dxby_reg, dybx_reg;
    seg_flags_t           flags2_reg;

    // Stage 3 cross products
    logic signed [CW-1:0] den_reg, pn_reg, qn_reg;
    seg_flags_t           flags3_reg;

    // Stage 4 output
    logic  crosses_next;
    case_t case_next;
    logic  crosses_reg;
    case_t case_reg;

    logic signed [CW:0] dp;
    logic signed [CW:0] dq;
    logic               den_zero;
    logic               pos_hit;
    logic               neg_hit;

    // A stage moves when it is empty or the next stage takes its item
    always_comb
    begin
        adv[NSTAGE-1] = !v_reg[NSTAGE-1] || !result_stall;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign pair_stall   = !adv[0];
    assign result_valid = v_reg[NSTAGE-1];
    assign crosses      = crosses_reg;
    assign case_taken   = case_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= pair_valid;
            end
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Stage 1: vectors and compare flags
    segint_classify #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_classify (
        .a1x   (first_start_x),
        .a1y   (first_start_y),
        .a2x   (first_end_x),
        .a2y   (first_end_y),
        .b1x   (second_start_x),
        .b1y   (second_start_y),
        .b2x   (second_end_x),
        .b2y   (second_end_y),
        .ax    (ax_next),
        .ay    (ay_next),
        .bx    (bx_next),
        .by    (by_next),
        .dx    (dx_next),
        .dy    (dy_next),
        .flags (flags_next)
    );

    always_ff @(posedge clk)
    begin
        if (adv[0] && pair_valid)
        begin
            ax_reg     <= ax_next;
            ay_reg     <= ay_next;
            bx_reg     <= bx_next;
            by_reg     <= by_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            flags1_reg <= flags_next;
        end
    end

    // Stage 2: the six partial products
    always_ff @(posedge clk)
    begin
        if (adv[1] && v_reg[0])
        begin
            axby_reg   <= PW'(ax_reg) * PW'(by_reg);
            aybx_reg   <= PW'(ay_reg) * PW'(bx_reg);
            axdy_reg   <= PW'(ax_reg) * PW'(dy_reg);
            aydx_reg   <= PW'(ay_reg) * PW'(dx_reg);
            dxby_reg   <= PW'(dx_reg) * PW'(by_reg);
            dybx_reg   <= PW'(dy_reg) * PW'(bx_reg);
            flags2_reg <= flags1_reg;
        end
    end

    // Stage 3: denominator and the two parameter numerators
    always_ff @(posedge clk)
    begin
        if (adv[2] && v_reg[1])
        begin
            den_reg    <= CW'(axby_reg) - CW'(aybx_reg);
            pn_reg     <= CW'(dxby_reg) - CW'(dybx_reg);
            qn_reg     <= CW'(aydx_reg) - CW'(axdy_reg);
            flags3_reg <= flags2_reg;
        end
    end

    // Stage 4: sign tests; both parameters strictly inside (0,1)
    assign dp       = (CW+1)'(den_reg) - (CW+1)'(pn_reg);
    assign dq       = (CW+1)'(den_reg) - (CW+1)'(qn_reg);
    assign den_zero = (den_reg == '0);
    assign pos_hit  = (pn_reg > 0) && (dp > 0) && (qn_reg > 0) && (dq > 0);
    assign neg_hit  = (pn_reg < 0) && (dp < 0) && (qn_reg < 0) && (dq < 0);

    // Rule selection; collinear when the offset cross product is zero
    always_comb
    begin
        if (flags3_reg.both_vert)
        begin
            case_next    = CASE_VERTICAL;
            crosses_next = flags3_reg.vert_hit;
        end
        else if (flags3_reg.nonvert && den_zero)
        begin
            case_next    = CASE_PARALLEL;
            crosses_next = (qn_reg == '0) && flags3_reg.box_hit;
        end
        else
        begin
            case_next    = CASE_GENERAL;
            crosses_next = !den_zero && (den_reg[CW-1] ? neg_hit : pos_hit);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3] && v_reg[2])
        begin
            crosses_reg <= crosses_next;
            case_reg    <= case_next;
        end
    end

    // Two vertical segments always give a zero denominator
    assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[2] && flags3_reg.both_vert) |-> (den_reg == '0))
    else $error("vertical pair with nonzero denominator");

    // Pairs are refused only when every stage is full and the output is held
    assert property (@(posedge clk) disable iff (!rst_n)
        pair_stall |-> ((&v_reg) && result_stall))
    else $error("pair stalled while pipeline has room");

    // A full pipeline facing a stalled receiver must refuse new pairs
    assert property (@(posedge clk) disable iff (!rst_n)
        ((&v_reg) && result_stall) |-> pair_stall)
    else $error("pair taken while pipeline full and stalled");

endmodule
